// ===== sv/mass_flux_divergence_stencil_macros.svh =====
// Assertion macros for the mass flux divergence stencil.
`ifndef MASS_FLUX_DIVERGENCE_STENCIL_MACROS_SVH
`define MASS_FLUX_DIVERGENCE_STENCIL_MACROS_SVH

`ifndef SYNTHESIS
`define MFD_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("mass flux stencil: same-cycle check failed");
`define MFD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("mass flux stencil: next-cycle check failed");
`else
`define MFD_ASSERT_NOW(lbl, ck, rn, ante, cons)
`define MFD_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ===== sv/mfd_pkg.sv =====
// Shared types and constants of the mass flux divergence stencil.
package mfd_pkg;

	localparam int DIM_W        = 7;
	localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;
	localparam logic [DIM_W-1:0] DIM_MIN   = 7'd3;
	localparam int MAX_ROWS_DEF = 64;
	localparam int MAX_COLS_DEF = 64;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = DIM_W;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

	localparam int SAMPLE_W = 16;
	localparam int DIV_W    = 40;

	// results released per accepted word
	localparam int GRP_W = 3;
	localparam logic [GRP_W-1:0] RES_PER_STEP = 3'd4;
	localparam int PEND_W = 4;

	localparam int WORK_Q_DEPTH = 4;
	localparam int GRP_Q_DEPTH  = 16;

	typedef struct packed {
		logic [SAMPLE_W-1:0] u;
		logic [SAMPLE_W-1:0] v;
		logic [SAMPLE_W-1:0] rho;
	} sample_t;

	typedef struct packed {
		logic        [15:0] rho_c;
		logic signed [15:0] u_c;
		logic signed [15:0] v_c;
		logic signed [17:0] dsum;
		logic signed [16:0] drx;
		logic signed [16:0] dry;
	} ops_t;

	typedef struct packed {
		logic top;
		logic bottom;
		logic left;
		logic right;
		logic last;
	} border_t;

endpackage

// ===== sv/mfd_fifo.sv =====
// Small register FIFO between the front and back halves.
module mfd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [AW:0]      count_q;

	assign full      = (count_q == (AW+1)'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (AW+1)'(1);
				2'b01:   count_q <= count_q - (AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/mfd_front.sv =====
// Front half: config registers, raster counters, line memory and operand differences.
module mfd_front #(
	parameter int MAX_ROWS = mfd_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = mfd_pkg::MAX_COLS_DEF,
	localparam int RW = $clog2(MAX_ROWS),
	localparam int CW = $clog2(MAX_COLS)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [mfd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mfd_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [mfd_pkg::SAMPLE_W-1:0] u_sample,
	input  logic signed [mfd_pkg::SAMPLE_W-1:0] v_sample,
	input  logic [mfd_pkg::SAMPLE_W-1:0]        rho_sample,
	output logic                                work_push,
	output mfd_pkg::ops_t                       work_ops,
	output mfd_pkg::border_t                    work_flags,
	output logic [RW-1:0]                       work_row,
	output logic [CW-1:0]                       work_col,
	input  logic                                work_full,
	output logic                                grp_push,
	output logic [mfd_pkg::GRP_W-1:0]           grp_size,
	input  logic                                grp_full
);

	localparam int DW_R  = (RW + 1 > mfd_pkg::DIM_W) ? RW + 1 : mfd_pkg::DIM_W;
	localparam int DW_C  = (CW + 1 > mfd_pkg::DIM_W) ? CW + 1 : mfd_pkg::DIM_W;
	localparam int AW    = CW + 1;
	localparam int DEPTH = 2 ** AW;
	localparam int TW    = mfd_pkg::PEND_W + 1;

	logic [mfd_pkg::DIM_W-1:0] grid_rows_q, grid_cols_q;
	logic [DW_R-1:0] rows_raw, rows_eff, row_x;
	logic [DW_C-1:0] cols_raw, cols_eff, col_x;
	logic [RW-1:0]   row_q;
	logic [CW-1:0]   col_q;
	logic            accept, wrap_col, wrap_row, is_site;
	logic            top, bottom, left, right;
	logic [1:0]      n_rows, n_cols;
	logic [3:0]      copies;
	logic [TW-1:0]   total;
	logic [mfd_pkg::PEND_W-1:0] pend_q;
	logic [AW-1:0]   wr_addr, nxt_addr;

	mfd_pkg::sample_t line_mem [DEPTH];
	mfd_pkg::sample_t smp_in, smp_s1, cur_s1, nxt_s1, w1_q, w0_q;
	mfd_pkg::border_t flags_s1;
	logic [RW-1:0]    row_s1;
	logic [CW-1:0]    col_s1;
	logic             s1_valid_q, s1_site_q, s1_go;
	logic signed [16:0] du, dv;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= mfd_pkg::DIM_RESET;
			grid_cols_q <= mfd_pkg::DIM_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				mfd_pkg::REG_GRID_ROWS: grid_rows_q <= cfg_wr_data;
				mfd_pkg::REG_GRID_COLS: grid_cols_q <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	assign rows_raw = DW_R'(grid_rows_q);
	assign cols_raw = DW_C'(grid_cols_q);

	always_comb begin
		if (rows_raw < DW_R'(mfd_pkg::DIM_MIN)) begin
			rows_eff = DW_R'(mfd_pkg::DIM_MIN);
		end else if (rows_raw > DW_R'(MAX_ROWS)) begin
			rows_eff = DW_R'(MAX_ROWS);
		end else begin
			rows_eff = rows_raw;
		end
		if (cols_raw < DW_C'(mfd_pkg::DIM_MIN)) begin
			cols_eff = DW_C'(mfd_pkg::DIM_MIN);
		end else if (cols_raw > DW_C'(MAX_COLS)) begin
			cols_eff = DW_C'(MAX_COLS);
		end else begin
			cols_eff = cols_raw;
		end
	end

	// classify the arriving word: the cell above it is computed now
	assign row_x    = DW_R'(row_q);
	assign col_x    = DW_C'(col_q);
	assign wrap_col = (col_x + DW_C'(1)) >= cols_eff;
	assign wrap_row = (row_x + DW_R'(1)) >= rows_eff;
	assign is_site  = (row_x >= DW_R'(2)) && (row_x < rows_eff) &&
	                  (col_x >= DW_C'(1)) && ((col_x + DW_C'(2)) <= cols_eff);
	assign top      = (row_x == DW_R'(2));
	assign bottom   = (row_x == rows_eff - DW_R'(1));
	assign left     = (col_x == DW_C'(1));
	assign right    = ((col_x + DW_C'(2)) == cols_eff);
	assign n_rows   = 2'd1 + {1'b0, top} + {1'b0, bottom};
	assign n_cols   = 2'd1 + {1'b0, left} + {1'b0, right};
	assign copies   = is_site ? ({2'b00, n_rows} * {2'b00, n_cols}) : 4'd0;

	// results released per word: at most four, the rest wait for later words
	assign total    = TW'(pend_q) + TW'(copies);
	assign grp_size = (total > TW'(mfd_pkg::RES_PER_STEP)) ? mfd_pkg::RES_PER_STEP :
	                  total[mfd_pkg::GRP_W-1:0];

	assign in_stall = grp_full || (s1_valid_q && s1_site_q && work_full);
	assign accept   = in_valid && !in_stall;
	assign grp_push = accept && (grp_size != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			pend_q <= '0;
		end else if (accept) begin
			pend_q <= mfd_pkg::PEND_W'(total - TW'(grp_size));
			if (wrap_col) begin
				col_q <= '0;
				row_q <= wrap_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// line memory: one half per row parity. The second port runs one column ahead
	// on the previous row; at a row end it fetches column 0 of the row just done.
	assign smp_in   = mfd_pkg::sample_t'({u_sample, v_sample, rho_sample});
	assign wr_addr  = {row_q[0], col_q};
	assign nxt_addr = wrap_col ? {row_q[0], CW'(0)} : {~row_q[0], col_q + CW'(1)};

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1            <= line_mem[wr_addr];
			nxt_s1            <= line_mem[nxt_addr];
			line_mem[wr_addr] <= smp_in;
			w1_q              <= nxt_s1;
			w0_q              <= w1_q;
			smp_s1            <= smp_in;
			row_s1            <= row_q - RW'(1);
			col_s1            <= col_q;
			flags_s1          <= '{top: top, bottom: bottom, left: left, right: right,
			                       last: bottom && right};
		end
	end

	assign s1_go = !s1_site_q || !work_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s1_site_q  <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
			s1_site_q  <= is_site;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	// window: w0 = prev[c-1], w1 = prev[c], nxt = prev[c+1], cur = two rows back
	assign du = 17'($signed(smp_s1.u)) - 17'($signed(cur_s1.u));
	assign dv = 17'($signed(nxt_s1.v)) - 17'($signed(w0_q.v));

	assign work_push       = s1_valid_q && s1_site_q && !work_full;
	assign work_ops.rho_c  = w1_q.rho;
	assign work_ops.u_c    = $signed(w1_q.u);
	assign work_ops.v_c    = $signed(w1_q.v);
	assign work_ops.dsum   = 18'(du) + 18'(dv);
	assign work_ops.drx    = $signed({1'b0, smp_s1.rho}) - $signed({1'b0, cur_s1.rho});
	assign work_ops.dry    = $signed({1'b0, nxt_s1.rho}) - $signed({1'b0, w0_q.rho});
	assign work_flags      = flags_s1;
	assign work_row        = row_s1;
	assign work_col        = col_s1;

endmodule

// ===== sv/mfd_back.sv =====
// Back half: products, halving, border fan-out and per-word result tagging.
module mfd_back #(
	parameter int MAX_ROWS = mfd_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = mfd_pkg::MAX_COLS_DEF,
	localparam int RW = $clog2(MAX_ROWS),
	localparam int CW = $clog2(MAX_COLS)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             work_valid,
	output logic                             work_pop,
	input  mfd_pkg::ops_t                    work_ops,
	input  mfd_pkg::border_t                 work_flags,
	input  logic [RW-1:0]                    work_row,
	input  logic [CW-1:0]                    work_col,
	input  logic                             grp_valid,
	output logic                             grp_pop,
	input  logic [mfd_pkg::GRP_W-1:0]        grp_size,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [RW-1:0]                    out_row,
	output logic [CW-1:0]                    out_col,
	output logic signed [mfd_pkg::DIV_W-1:0] div_value,
	output logic                             run_last,
	output logic                             grid_done
);

	logic signed [34:0] prod_a, prod_a_s1;
	logic signed [32:0] prod_u, prod_v, prod_u_s1, prod_v_s1;
	logic signed [35:0] sum;
	logic [RW-1:0]      row_s1, row_s2, row_lo;
	logic [CW-1:0]      col_s1, col_s2, col_lo;
	mfd_pkg::border_t   flags_s1, flags_s2;
	logic signed [mfd_pkg::DIV_W-1:0] val_s2;
	logic               s1_valid_q, s2_valid_q, out_valid_q;
	logic               s1_load, s2_load, s2_done, emit, out_free, copy_last, step_end;
	logic [1:0]         ra_q, ca_q, ra_max, ca_max, grp_cnt_q;

	// stage 1: three products
	assign prod_a = $signed({1'b0, work_ops.rho_c}) * work_ops.dsum;
	assign prod_u = work_ops.u_c * work_ops.drx;
	assign prod_v = work_ops.v_c * work_ops.dry;

	// stage 2: sum, halve toward minus infinity
	assign sum = 36'(prod_a_s1) + 36'(prod_u_s1) + 36'(prod_v_s1);

	// fan-out over the border copies in raster order
	assign ra_max    = {1'b0, flags_s2.top} + {1'b0, flags_s2.bottom};
	assign ca_max    = {1'b0, flags_s2.left} + {1'b0, flags_s2.right};
	assign copy_last = (ra_q == ra_max) && (ca_q == ca_max);
	assign row_lo    = flags_s2.top ? '0 : row_s2;
	assign col_lo    = flags_s2.left ? '0 : col_s2;

	assign out_free = !out_valid_q || !out_stall;
	assign emit     = s2_valid_q && grp_valid && out_free;
	assign s2_done  = emit && copy_last;
	assign s2_load  = s1_valid_q && (!s2_valid_q || s2_done);
	assign s1_load  = work_valid && (!s1_valid_q || s2_load);
	assign work_pop = s1_load;

	// each word releases grp_size results; the last one carries run_last
	assign step_end = ({1'b0, grp_cnt_q} + 3'd1) == grp_size;
	assign grp_pop  = emit && step_end;

	always_ff @(posedge clk) begin
		if (s1_load) begin
			prod_a_s1 <= prod_a;
			prod_u_s1 <= prod_u;
			prod_v_s1 <= prod_v;
			row_s1    <= work_row;
			col_s1    <= work_col;
			flags_s1  <= work_flags;
		end
		if (s2_load) begin
			val_s2   <= mfd_pkg::DIV_W'(sum >>> 1);
			row_s2   <= row_s1;
			col_s2   <= col_s1;
			flags_s2 <= flags_s1;
		end
		if (emit) begin
			out_row   <= row_lo + RW'(ra_q);
			out_col   <= col_lo + CW'(ca_q);
			div_value <= val_s2;
			run_last  <= step_end;
			grid_done <= flags_s2.last && copy_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			ra_q        <= '0;
			ca_q        <= '0;
			grp_cnt_q   <= '0;
		end else begin
			if (s1_load) begin
				s1_valid_q <= 1'b1;
			end else if (s2_load) begin
				s1_valid_q <= 1'b0;
			end
			if (s2_load) begin
				s2_valid_q <= 1'b1;
			end else if (s2_done) begin
				s2_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (emit) begin
				if (copy_last) begin
					ra_q <= '0;
					ca_q <= '0;
				end else if (ca_q == ca_max) begin
					ca_q <= '0;
					ra_q <= ra_q + 2'd1;
				end else begin
					ca_q <= ca_q + 2'd1;
				end
				grp_cnt_q <= step_end ? 2'd0 : grp_cnt_q + 2'd1;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/mass_flux_divergence_stencil.sv =====
// Top level of the streaming mass flux divergence stencil.
//
//   channel  dir  handshake           payload
//   in       in   in_valid/in_stall   u_sample, v_sample, rho_sample
//   out      out  out_valid/out_stall out_row, out_col, div_value, run_last, grid_done
//   cfg      in   cfg_wr_en           cfg_index, cfg_wr_data
//
// Takes one word per cycle while in_stall is low; emits up to one result per cycle
// while out_stall is low, so border cells copied two to nine times hold the input
// back through the work queue. The word below a cell passes the line memory read and
// operands, queue, product stage, sum stage and output reg before its first result.
// Line memory is 2*MAX_COLS words and needs no clearing after reset.
// Grids of three rows or columns may hold a result back until the next word.
`include "mass_flux_divergence_stencil_macros.svh"

module mass_flux_divergence_stencil #(
	parameter int MAX_ROWS = mfd_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = mfd_pkg::MAX_COLS_DEF,
	localparam int RW = $clog2(MAX_ROWS),
	localparam int CW = $clog2(MAX_COLS)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [mfd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mfd_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [mfd_pkg::SAMPLE_W-1:0] u_sample,
	input  logic signed [mfd_pkg::SAMPLE_W-1:0] v_sample,
	input  logic [mfd_pkg::SAMPLE_W-1:0]        rho_sample,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [RW-1:0]                       out_row,
	output logic [CW-1:0]                       out_col,
	output logic signed [mfd_pkg::DIV_W-1:0]    div_value,
	output logic                                run_last,
	output logic                                grid_done
);

	localparam int OPS_W  = $bits(mfd_pkg::ops_t);
	localparam int FLG_W  = $bits(mfd_pkg::border_t);
	localparam int WORK_W = OPS_W + FLG_W + RW + CW;

	logic                    work_push, work_full, work_pop, work_valid;
	mfd_pkg::ops_t           f_ops, b_ops;
	mfd_pkg::border_t        f_flags, b_flags;
	logic [RW-1:0]           f_row, b_row;
	logic [CW-1:0]           f_col, b_col;
	logic [WORK_W-1:0]       work_wdata, work_rdata;
	logic                    grp_push, grp_full, grp_pop, grp_valid;
	logic [mfd_pkg::GRP_W-1:0] grp_wsize, grp_rsize;
	logic                    done_fire, at_origin;

	mfd_front #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.u_sample    (u_sample),
		.v_sample    (v_sample),
		.rho_sample  (rho_sample),
		.work_push   (work_push),
		.work_ops    (f_ops),
		.work_flags  (f_flags),
		.work_row    (f_row),
		.work_col    (f_col),
		.work_full   (work_full),
		.grp_push    (grp_push),
		.grp_size    (grp_wsize),
		.grp_full    (grp_full)
	);

	assign work_wdata = {f_ops, f_flags, f_row, f_col};

	mfd_fifo #(
		.WIDTH (WORK_W),
		.DEPTH (mfd_pkg::WORK_Q_DEPTH)
	) u_work_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (work_push),
		.push_data (work_wdata),
		.full      (work_full),
		.pop       (work_pop),
		.pop_data  (work_rdata),
		.not_empty (work_valid)
	);

	assign {b_ops, b_flags, b_row, b_col} = work_rdata;

	mfd_fifo #(
		.WIDTH (mfd_pkg::GRP_W),
		.DEPTH (mfd_pkg::GRP_Q_DEPTH)
	) u_grp_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (grp_push),
		.push_data (grp_wsize),
		.full      (grp_full),
		.pop       (grp_pop),
		.pop_data  (grp_rsize),
		.not_empty (grp_valid)
	);

	mfd_back #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.work_valid (work_valid),
		.work_pop   (work_pop),
		.work_ops   (b_ops),
		.work_flags (b_flags),
		.work_row   (b_row),
		.work_col   (b_col),
		.grp_valid  (grp_valid),
		.grp_pop    (grp_pop),
		.grp_size   (grp_rsize),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_row    (out_row),
		.out_col    (out_col),
		.div_value  (div_value),
		.run_last   (run_last),
		.grid_done  (grid_done)
	);

	assign done_fire = out_valid && !out_stall && grid_done;
	assign at_origin = (out_row == '0) && (out_col == '0);

	// the final cell of a grid always closes its word's results
	`MFD_ASSERT_NOW(a_done_closes_word, clk, arst_n, out_valid && grid_done, run_last)
	// the next grid starts at the top-left corner
	`MFD_ASSERT_NEXT(a_grid_restarts, clk, arst_n, done_fire, !out_valid || at_origin)

endmodule

// ===== sim/tb.sv =====
// Testbench for the mass flux divergence stencil: predictor, stimulus and result checks.
`timescale 1ns / 1ps

module tb;

	localparam int MAX_R = mfd_pkg::MAX_ROWS_DEF;
	localparam int MAX_C = mfd_pkg::MAX_COLS_DEF;
	localparam int ROW_W = $clog2(MAX_R);
	localparam int COL_W = $clog2(MAX_C);
	localparam int DIM_BITS = mfd_pkg::DIM_W;
	localparam int HOLD_DEPTH = 16;
	localparam int DRAIN_CYCLES = 20;
	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_WORDS = 12;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [mfd_pkg::DIV_W-1:0] value;
		logic             last;
		logic             done;
	} cell_div_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [mfd_pkg::CFG_IDX_W-1:0] cfg_index = mfd_pkg::REG_GRID_ROWS;
	logic [mfd_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [mfd_pkg::SAMPLE_W-1:0] u_sample = '0;
	logic signed [mfd_pkg::SAMPLE_W-1:0] v_sample = '0;
	logic [mfd_pkg::SAMPLE_W-1:0] rho_sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [ROW_W-1:0] out_row;
	logic [COL_W-1:0] out_col;
	logic signed [mfd_pkg::DIV_W-1:0] div_value;
	logic run_last;
	logic grid_done;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int fail_count = 0;
	int quiet_cycles = 0;

	// predictor state
	logic [15:0] u_line [2*MAX_C];
	logic [15:0] v_line [2*MAX_C];
	logic [15:0] rho_line [2*MAX_C];
	int row_pos = 0;
	int col_pos = 0;
	logic [DIM_BITS-1:0] rows_reg = mfd_pkg::DIM_RESET;
	logic [DIM_BITS-1:0] cols_reg = mfd_pkg::DIM_RESET;
	cell_div_t queued_cells[$];
	cell_div_t due_cells[$];

	mass_flux_divergence_stencil u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.u_sample    (u_sample),
		.v_sample    (v_sample),
		.rho_sample  (rho_sample),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_row     (out_row),
		.out_col     (out_col),
		.div_value   (div_value),
		.run_last    (run_last),
		.grid_done   (grid_done)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	function automatic int eff_dim(logic [DIM_BITS-1:0] d, int hi);
		if (d < mfd_pkg::DIM_MIN)
			return mfd_pkg::DIM_MIN;
		if (d > hi)
			return hi;
		return int'(d);
	endfunction

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 15))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// mostly in range, now and then below the minimum so it clamps
	function automatic logic [DIM_BITS-1:0] pick_dim(int hi);
		if ($urandom_range(0, 5) == 0)
			return DIM_BITS'($urandom_range(0, 2));
		return DIM_BITS'($urandom_range(3, hi));
	endfunction

	// One accepted word: compute any interior cell it completes, fan it out to the
	// border copies, then release at most RES_PER_STEP results in raster order.
	task automatic advance_stencil(input logic [15:0] u_in, v_in, rho_in);
		int rows, cols, r, c, cur, prv, i, j, rlo, rhi, clo, chi, n;
		longint u_c, v_c, rho_c, du, dv, drx, dry, sum, half;
		bit last_cell;
		cell_div_t res;
		rows = eff_dim(rows_reg, MAX_R);
		cols = eff_dim(cols_reg, MAX_C);
		r = row_pos;
		c = col_pos;
		cur = (r % 2) * MAX_C;
		prv = ((r + 1) % 2) * MAX_C;
		if (r >= 2 && r <= rows - 1 && c >= 1 && c + 2 <= cols) begin
			u_c = $signed(u_line[prv + c]);
			v_c = $signed(v_line[prv + c]);
			rho_c = rho_line[prv + c];
			du = $signed(u_in) - $signed(u_line[cur + c]);
			dv = $signed(v_line[prv + c + 1]) - $signed(v_line[prv + c - 1]);
			drx = rho_in - rho_line[cur + c];
			dry = rho_line[prv + c + 1] - rho_line[prv + c - 1];
			sum = rho_c * (du + dv) + u_c * drx + v_c * dry;
			half = sum >>> 1;
			i = r - 1;
			j = c;
			rlo = (i == 1) ? 0 : i;
			rhi = (i == rows - 2) ? i + 1 : i;
			clo = (j == 1) ? 0 : j;
			chi = (j == cols - 2) ? j + 1 : j;
			last_cell = (i == rows - 2) && (j == cols - 2);
			for (int a = rlo; a <= rhi; a++) begin
				for (int b = clo; b <= chi; b++) begin
					if (queued_cells.size() < HOLD_DEPTH) begin
						res.row = ROW_W'(a);
						res.col = COL_W'(b);
						res.value = half[mfd_pkg::DIV_W-1:0];
						res.last = 1'b0;
						res.done = last_cell && a == rhi && b == chi;
						queued_cells.push_back(res);
					end
				end
			end
		end
		u_line[cur + c] = u_in;
		v_line[cur + c] = v_in;
		rho_line[cur + c] = rho_in;
		c++;
		if (c >= cols) begin
			c = 0;
			r++;
			if (r >= rows)
				r = 0;
		end
		row_pos = r;
		col_pos = c;
		n = (queued_cells.size() < mfd_pkg::RES_PER_STEP) ? queued_cells.size() :
		    mfd_pkg::RES_PER_STEP;
		for (int k = 0; k < n; k++) begin
			res = queued_cells.pop_front();
			res.last = (k == n - 1);
			due_cells.push_back(res);
		end
	endtask

	task automatic send_word(input logic [15:0] u, v, rho);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		u_sample <= u;
		v_sample <= v;
		rho_sample <= rho;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		advance_stencil(u, v, rho);
	endtask

	// stop sending, let every due result arrive, then give the pipeline time to empty
	task automatic quiesce();
		in_valid <= 1'b0;
		while (due_cells.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_dims(input logic [DIM_BITS-1:0] rows, cols);
		quiesce();
		cfg_wr_en <= 1'b1;
		cfg_index <= mfd_pkg::REG_GRID_ROWS;
		cfg_wr_data <= rows;
		@(posedge clk);
		rows_reg = rows;
		cfg_index <= mfd_pkg::REG_GRID_COLS;
		cfg_wr_data <= cols;
		@(posedge clk);
		cols_reg = cols;
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_grid();
		repeat (eff_dim(rows_reg, MAX_R) * eff_dim(cols_reg, MAX_C))
			send_word(pick_sample(), pick_sample(), pick_sample());
	endtask

	// 3x3 grid built so the one interior cell hits the largest positive sum;
	// its nine copies overflow the per-word release and the last one waits
	task automatic test_peak_values();
		logic [15:0] u, v, rho;
		write_dims(7'd3, 7'd3);
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				u = (c != 1) ? 16'h0000 : (r == 0) ? 16'h8000 : 16'h7FFF;
				v = (r != 1) ? 16'h0000 : (c == 0) ? 16'h8000 : 16'h7FFF;
				rho = (r == 0 || (r == 1 && c == 0)) ? 16'h0000 : 16'hFFFF;
				send_word(u, v, rho);
			end
		end
	endtask

	// rows below the minimum clamp to 3; large negative odd sums check the floor halving
	task automatic test_clamped_low();
		logic [15:0] u, v, rho;
		write_dims(7'd1, 7'd4);
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 4; c++) begin
				u = (r == 2) ? 16'h8000 : 16'h7FFF;
				v = (c >= 2) ? 16'h8000 : 16'h7FFF;
				rho = (r == 2) ? 16'h0000 : 16'hFFFF;
				send_word(u, v, rho);
			end
		end
	endtask

	// widest grid: a column count above the maximum clamps
	task automatic test_full_width_dims();
		write_dims(7'd3, 7'd127);
		send_grid();
	endtask

	// resize while the raster position is mid-grid; line memory is fully written by now
	task automatic test_midgrid_resize();
		int burst;
		write_dims(pick_dim(8), pick_dim(8));
		repeat (3) begin
			burst = $urandom_range(3, 8);
			repeat (burst) send_word(pick_sample(), pick_sample(), pick_sample());
			// results held for later words leave before the grid changes
			while (queued_cells.size() != 0)
				send_word(pick_sample(), pick_sample(), pick_sample());
			write_dims(pick_dim(8), pick_dim(8));
		end
		while (row_pos != 0 || col_pos != 0)
			send_word(pick_sample(), pick_sample(), pick_sample());
	endtask

	task automatic test_random_grids(input int send_pct, recv_pct);
		int sent;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			write_dims(pick_dim(6), pick_dim(8));
			send_grid();
			sent += eff_dim(rows_reg, MAX_R) * eff_dim(cols_reg, MAX_C);
		end
	endtask

	always @(posedge clk) begin : check_results
		cell_div_t want;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (out_valid && !out_stall) begin
				if (due_cells.size() == 0) begin
					$error("result row %0d col %0d arrived with none due", out_row, out_col);
					fail_count++;
				end else begin
					want = due_cells.pop_front();
					if (out_row !== want.row) begin
						$error("out_row: expected %0d, got %0d", want.row, out_row);
						fail_count++;
					end
					if (out_col !== want.col) begin
						$error("out_col: expected %0d, got %0d", want.col, out_col);
						fail_count++;
					end
					if (div_value !== want.value) begin
						$error("div_value: expected %0d, got %0d", $signed(want.value),
							div_value);
						fail_count++;
					end
					if (run_last !== want.last) begin
						$error("run_last: expected %0d, got %0d", want.last, run_last);
						fail_count++;
					end
					if (grid_done !== want.done) begin
						$error("grid_done: expected %0d, got %0d", want.done, grid_done);
						fail_count++;
					end
				end
			end
		end
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("tb NOT OK");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 11;
		recv_idle_pct = 51;
		test_peak_values();
		test_clamped_low();
		test_full_width_dims();
		test_midgrid_resize();
		test_random_grids(51, 11);
		test_random_grids(0, 0);
		quiesce();
		if (fail_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/mfd_pkg.sv
sv/mfd_fifo.sv
sv/mfd_front.sv
sv/mfd_back.sv
sv/mass_flux_divergence_stencil.sv
sim/tb.sv
